// File: rtl/core/ilbp_pkg.sv
// ----------------------------------------------------------------------------
// ilbp_pkg
// Shared types, constants and helpers for the ILBP histogram block.
// ----------------------------------------------------------------------------
package ilbp_pkg;

   // Default sizes for the top-level parameters
   localparam int MAX_WIDTH_DEF   = 1024;
   localparam int COUNT_WIDTH_DEF = 20;

   // Fixed field widths
   localparam int PIX_W       = 8;
   localparam int CFG_W       = 11;
   localparam int CODE_W      = 9;
   localparam int SUM_W       = 12;   // holds 9 * 255
   localparam int WIN_N       = 9;
   localparam int NBINS       = 512;
   localparam int RSP_COUNT_W = 20;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;

   localparam logic [CFG_W-1:0] WIDTH_RST = 11'd1024;
   localparam int               MIN_WIDTH = 3;

   // Request kinds carried in req_tuser
   typedef enum logic [1:0] {
      REQ_PIXEL = 2'd0,
      REQ_READ  = 2'd1,
      REQ_CLEAR = 2'd2
   } req_kind_type;

   // Result kinds carried in rsp_tuser
   localparam logic RSP_CODE  = 1'b0;
   localparam logic RSP_COUNT = 1'b1;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WIN,
      ST_CODE,
      ST_HIST,
      ST_READ
   } state_type;

   // Window status from the line-store unit
   typedef struct packed {
      logic done;
      logic hit;
   } win_type;

   // The nine window pixels in code-bit order (index 0 gives the MSB)
   typedef logic [WIN_N-1:0][PIX_W-1:0] win_pix_type;

   // Smallest of the nine cyclic rotations of a code
   function automatic logic [CODE_W-1:0] rot_min(input logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] best;
      logic [CODE_W-1:0] r;
      best = code;
      r    = code;
      for (int k = 1; k < CODE_W; k++) begin
         r = {r[CODE_W-2:0], r[CODE_W-1]};
         if (r < best) best = r;
      end
      return best;
   endfunction

endpackage

// File: rtl/core/ilbp_ram.sv
// ----------------------------------------------------------------------------
// ilbp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ilbp_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ilbp_window.sv
// ----------------------------------------------------------------------------
// ilbp_window
// Two line stores, raster position and the 3x3 window registers.
// ----------------------------------------------------------------------------
module ilbp_window #(
   parameter int MAX_WIDTH = ilbp_pkg::MAX_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      frame_start,
   input  logic [ilbp_pkg::PIX_W-1:0] pixel,
   input  logic [ilbp_pkg::CFG_W-1:0] image_width,
   output ilbp_pkg::win_type         win,
   output ilbp_pkg::win_pix_type     pix
);
   import ilbp_pkg::*;

   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int WW     = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);

   logic [WW-1:0]     w_ext;
   logic [WW-1:0]     w_eff;
   logic [ADDR_W-1:0] last_col;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [1:0]        row_ff, row_in;
   logic [1:0]        row_cur;
   logic [ADDR_W-1:0] c_cur;
   logic [ADDR_W-1:0] c_ff;
   logic [PIX_W-1:0]  px_ff;
   logic              hit_s1_ff;
   logic              s1_vld_ff;
   logic [PIX_W-1:0]  up_rd, lo_rd;
   logic [PIX_W-1:0]  wreg_ff [6];
   win_pix_type       pix_in;
   win_pix_type       pix_ff;
   logic              done_ff;
   logic              hit_ff;

   // Effective row width, clamped to the supported range
   always_comb begin
      w_ext = WW'(image_width);
      if (w_ext < WW'(MIN_WIDTH))      w_eff = WW'(MIN_WIDTH);
      else if (w_ext > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
      else                             w_eff = w_ext;
      last_col = ADDR_W'(w_eff - WW'(1));
   end

   // Column and row of the incoming pixel, and the next position
   always_comb begin
      row_cur = frame_start ? 2'd0 : row_ff;
      c_cur   = frame_start ? '0 : ((col_ff > last_col) ? last_col : col_ff);
      col_in  = col_ff;
      row_in  = row_ff;
      if (start) begin
         if (c_cur >= last_col) begin
            col_in = '0;
            row_in = (row_cur == 2'd2) ? row_cur : row_cur + 2'd1;
         end else begin
            col_in = c_cur + ADDR_W'(1);
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         s1_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         s1_vld_ff <= start;
         done_ff   <= s1_vld_ff;
      end
   end

   // Transaction payload held for the line-store update
   always_ff @(posedge clock) begin
      if (start) begin
         c_ff      <= c_cur;
         px_ff     <= pixel;
         hit_s1_ff <= (row_cur == 2'd2) && (c_cur >= ADDR_W'(2));
      end
   end

   // Line stores: read at the column on accept, write back in the following cycle
   ilbp_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_line_upper (
      .clock   (clock),
      .wr_en   (s1_vld_ff),
      .wr_addr (c_ff),
      .wr_data (lo_rd),
      .rd_en   (start),
      .rd_addr (c_cur),
      .rd_data (up_rd)
   );

   ilbp_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_line_lower (
      .clock   (clock),
      .wr_en   (s1_vld_ff),
      .wr_addr (c_ff),
      .wr_data (px_ff),
      .rd_en   (start),
      .rd_addr (c_cur),
      .rd_data (lo_rd)
   );

   // Window in code-bit order: clockwise from top-left, centre last
   always_comb begin
      pix_in[0] = wreg_ff[0];
      pix_in[1] = wreg_ff[3];
      pix_in[2] = up_rd;
      pix_in[3] = lo_rd;
      pix_in[4] = px_ff;
      pix_in[5] = wreg_ff[5];
      pix_in[6] = wreg_ff[2];
      pix_in[7] = wreg_ff[1];
      pix_in[8] = wreg_ff[4];
   end

   // Window columns shift left by one pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) wreg_ff[i] <= '0;
      end else if (s1_vld_ff) begin
         wreg_ff[0] <= wreg_ff[3];
         wreg_ff[1] <= wreg_ff[4];
         wreg_ff[2] <= wreg_ff[5];
         wreg_ff[3] <= up_rd;
         wreg_ff[4] <= lo_rd;
         wreg_ff[5] <= px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         pix_ff <= pix_in;
         hit_ff <= hit_s1_ff;
      end
   end

   assign win.done = done_ff;
   assign win.hit  = hit_ff;
   assign pix      = pix_ff;

endmodule

// File: rtl/core/ilbp_code.sv
// ----------------------------------------------------------------------------
// ilbp_code
// Three-stage pattern unit: window sum, threshold bits, rotation minimum.
// ----------------------------------------------------------------------------
module ilbp_code (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  ilbp_pkg::win_pix_type       pix,
   output logic                        code_vld,
   output logic [ilbp_pkg::CODE_W-1:0] code
);
   import ilbp_pkg::*;

   logic [SUM_W-1:0]  sum_in;
   logic [SUM_W-1:0]  sum_ff;
   win_pix_type       pix_ff;
   logic [CODE_W-1:0] bits_in;
   logic [CODE_W-1:0] bits_ff;
   logic [CODE_W-1:0] min_ff;
   logic              v1_ff, v2_ff, v3_ff;
   logic [SUM_W-1:0]  p9;

   // Stage 1: window sum
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < WIN_N; k++) sum_in = sum_in + SUM_W'(pix[k]);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         sum_ff <= sum_in;
         pix_ff <= pix;
      end
   end

   // Stage 2: one bit per pixel, set when nine times the pixel beats the sum
   always_comb begin
      bits_in = '0;
      p9      = '0;
      for (int k = 0; k < WIN_N; k++) begin
         p9 = (SUM_W'(pix_ff[k]) << 3) + SUM_W'(pix_ff[k]);
         bits_in[CODE_W-1-k] = (p9 > sum_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff) bits_ff <= bits_in;
   end

   // Stage 3: rotation-invariant code
   always_ff @(posedge clock) begin
      if (v2_ff) min_ff <= rot_min(bits_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign code_vld = v3_ff;
   assign code     = min_ff;

endmodule

// File: rtl/core/ilbp_histogram_top.sv
// ----------------------------------------------------------------------------
// ilbp_histogram_top
// Streaming rotation-invariant ILBP coder with a 512-bin saturating histogram.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. A pixel that completes no window
// passes the line-store read and the window register before the next
// transaction can be taken; a pixel that completes a window also passes the
// three pattern stages and the histogram read then write-back, and waits
// while the result register stays occupied. A clear request sweeps the
// histogram memory one bin per cycle, and after reset the same clearing
// pass runs before the first transaction is accepted; the width register
// can be written throughout. The result register lets a new transaction
// enter while the previous result waits to be taken.
// ----------------------------------------------------------------------------
module ilbp_histogram_top #(
   parameter int MAX_WIDTH   = ilbp_pkg::MAX_WIDTH_DEF,
   parameter int COUNT_WIDTH = ilbp_pkg::COUNT_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Width register
   input  logic                            csr_wr_en,
   input  logic [ilbp_pkg::CFG_W-1:0]      csr_wr_data,    // image_width
   // Request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ilbp_pkg::REQ_DATA_W-1:0] req_tdata,      // frame_start, pixel_value, bin_index
   input  logic [1:0]                      req_tuser,      // req_type
   // Result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ilbp_pkg::RSP_DATA_W-1:0] rsp_tdata,      // pattern_code, bin_count
   output logic                            rsp_tuser       // resp_kind
);
   import ilbp_pkg::*;

   localparam int BIN_W = $clog2(NBINS);
   localparam int CX_W  = (COUNT_WIDTH > RSP_COUNT_W) ? COUNT_WIDTH : RSP_COUNT_W;

   state_type           state_ff, state_in;
   logic [CFG_W-1:0]    width_ff;
   logic [BIN_W-1:0]    clr_ff, clr_in;
   logic [CODE_W-1:0]   code_hold_ff, code_hold_in;
   logic                req_acc;
   req_kind_type        req_kind;
   logic                frame_start;
   logic [PIX_W-1:0]    pixel_value;
   logic [BIN_W-1:0]    bin_index;
   logic                pix_start;
   logic                code_start;
   win_type             win;
   win_pix_type         win_pix;
   logic                code_vld;
   logic [CODE_W-1:0]   code;
   logic                hist_rd_en;
   logic [BIN_W-1:0]    hist_rd_addr;
   logic [COUNT_WIDTH-1:0] hist_rd_data;
   logic                hist_wr_en;
   logic [BIN_W-1:0]    hist_wr_addr;
   logic [COUNT_WIDTH-1:0] hist_wr_data;
   logic [CX_W-1:0]     cnt_ext;
   logic                out_free;
   logic                rsp_load;
   logic                rsp_kind_in;
   logic [CODE_W-1:0]   rsp_code_in;
   logic [RSP_COUNT_W-1:0] rsp_count_in;
   logic                rsp_tvalid_ff;
   logic                rsp_kind_ff;
   logic [CODE_W-1:0]   rsp_code_ff;
   logic [RSP_COUNT_W-1:0] rsp_count_ff;

   // Request unpacking
   assign req_kind    = req_kind_type'(req_tuser);
   assign frame_start = req_tdata[0];
   assign pixel_value = req_tdata[PIX_W:1];
   assign bin_index   = req_tdata[PIX_W+BIN_W:PIX_W+1];
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_acc     = req_tvalid && req_tready;

   // Width register
   always_ff @(posedge clock) begin
      if (reset)          width_ff <= WIDTH_RST;
      else if (csr_wr_en) width_ff <= csr_wr_data;
   end

   // Line stores and window
   ilbp_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock       (clock),
      .reset       (reset),
      .start       (pix_start),
      .frame_start (frame_start),
      .pixel       (pixel_value),
      .image_width (width_ff),
      .win         (win),
      .pix         (win_pix)
   );

   // Pattern unit
   ilbp_code u_code (
      .clock    (clock),
      .reset    (reset),
      .start    (code_start),
      .pix      (win_pix),
      .code_vld (code_vld),
      .code     (code)
   );

   // Histogram memory
   ilbp_ram #(.DATA_W(COUNT_WIDTH), .DEPTH(NBINS)) u_hist (
      .clock   (clock),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_en   (hist_rd_en),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   assign cnt_ext  = CX_W'(hist_rd_data);
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // Controller: next state and datapath strobes
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      code_hold_in = code_hold_ff;
      pix_start    = 1'b0;
      code_start   = 1'b0;
      hist_rd_en   = 1'b0;
      hist_rd_addr = bin_index;
      hist_wr_en   = 1'b0;
      hist_wr_addr = code_hold_ff;
      hist_wr_data = (hist_rd_data == '1) ? hist_rd_data : hist_rd_data + COUNT_WIDTH'(1);
      rsp_load     = 1'b0;
      rsp_kind_in  = RSP_CODE;
      rsp_code_in  = code_hold_ff;
      rsp_count_in = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            hist_wr_en   = 1'b1;
            hist_wr_addr = clr_ff;
            hist_wr_data = '0;
            clr_in       = clr_ff + BIN_W'(1);
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_kind)
                  REQ_PIXEL: begin
                     pix_start = 1'b1;
                     state_in  = ST_WIN;
                  end
                  REQ_READ: begin
                     hist_rd_en = 1'b1;
                     state_in   = ST_READ;
                  end
                  REQ_CLEAR: begin
                     clr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_WIN: begin
            if (win.done) begin
               code_start = win.hit;
               state_in   = win.hit ? ST_CODE : ST_IDLE;
            end
         end
         ST_CODE: begin
            if (code_vld) begin
               hist_rd_en   = 1'b1;
               hist_rd_addr = code;
               code_hold_in = code;
               state_in     = ST_HIST;
            end
         end
         ST_HIST: begin
            if (out_free) begin
               hist_wr_en = 1'b1;
               rsp_load   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_load     = 1'b1;
               rsp_kind_in  = RSP_COUNT;
               rsp_code_in  = '0;
               rsp_count_in = cnt_ext[RSP_COUNT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      code_hold_ff <= code_hold_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset)           rsp_tvalid_ff <= 1'b0;
      else if (rsp_load)   rsp_tvalid_ff <= 1'b1;
      else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_code_ff  <= rsp_code_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-CODE_W-RSP_COUNT_W){1'b0}}, rsp_count_ff, rsp_code_ff};

`ifndef SYNTHESIS
   // Reset always starts the histogram clearing pass from bin zero
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (state_ff == ST_CLEAR) && (clr_ff == '0))
      else $error("clearing pass not started after reset");

   // The pattern unit only finishes while the controller waits for it
   a_code_wait: assert property (@(posedge clock) disable iff (reset)
      code_vld |-> (state_ff == ST_CODE))
      else $error("pattern code arrived outside its wait state");

   // A histogram update is a saturating increment of the bin just read
   a_sat_inc: assert property (@(posedge clock) disable iff (reset)
      (hist_wr_en && (state_ff == ST_HIST)) |->
         (hist_wr_data == hist_rd_data + COUNT_WIDTH'(1)) ||
         ((hist_rd_data == '1) && (hist_wr_data == hist_rd_data)))
      else $error("histogram update is not a saturating increment");

   // Leaving the update state leaves a pattern result waiting
   a_code_result: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_HIST && state_ff == ST_IDLE && !$past(reset)) |->
         (rsp_tvalid && (rsp_tuser == RSP_CODE)))
      else $error("pattern result missing after histogram update");
`endif

endmodule
